// ----- rtl/core/dba_pkg.sv -----
// Shared types, codes and default sizes for the direction batch arbiter.
// Used by direction_batch_arbiter_core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dba_pkg;

   // Fixed field widths of the configuration and result ports.
   localparam int CFG_W     = 5;
   localparam int OCC_W     = 5;
   localparam int BATCH_W   = 5;
   localparam int CSR_IDX_W = 1;

   // Batch counter saturates here.
   localparam logic [BATCH_W-1:0] BATCH_SAT = '1;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_CAPACITY = 16;
   localparam int DEF_QUEUE_DEPTH  = 16;
   localparam int DEF_ID_BITS      = 8;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DN   = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      KIND_ADMITTED = 2'd0,
      KIND_QUEUED   = 2'd1,
      KIND_LEFT     = 2'd2,
      KIND_REJECTED = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY    = 1'b0,
      CSR_BATCH_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_ARRIVE = 1'b0,
      MODE_LEAVE  = 1'b1
   } mode_type;

   // Side 0 is the up queue, side 1 the down queue.
   function automatic dir_type side_to_dir(input logic side);
      return side ? DIR_DN : DIR_UP;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/direction_batch_arbiter_core.sv -----
// Direction batch arbiter: one-lane resource arbitration with per-direction wait queues.
// Depends on dba_pkg for codes, field widths and default parameters.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// An event (arrive or leave, direction, requester id) is taken at a rising edge with
// start high and busy low. Busy stays high while the event is processed. Every result
// beat is shown on the rsp_ ports for exactly one cycle with rsp_valid high; the
// receiver cannot stall, so nothing waits on it. rsp_last marks the final beat of an
// event, and busy is already low in that cycle, so the next start is taken right then.
// The first result passes through the decide and emit steps before it reaches the rsp_
// ports. An arrive, a rejected event, or a leave that frees no waiter gives one beat.
// A leave that drains queued requesters adds, per admitted waiter, a fetch step for
// the registered read of the queue memory, a pop step to admit, and an emit step.
// The admission check is a single compare unit shared by the decide and emit steps.
// The configuration channel (csr_) is always ready; the user must write it only while
// idle, which the block itself does not enforce.
// Reset (synchronous, active high) sets capacity and batch limit to 1, the direction
// to none, and clears occupancy, batch count, queue counts and queue pointers. Queue
// memory is not cleared; only counted entries are ever read.
module direction_batch_arbiter_core #(
   parameter int MAX_CAPACITY = dba_pkg::DEF_MAX_CAPACITY,
   parameter int QUEUE_DEPTH  = dba_pkg::DEF_QUEUE_DEPTH,
   parameter int ID_BITS      = dba_pkg::DEF_ID_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Command channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_mode,
   input  wire logic                          req_direction,
   input  wire logic [ID_BITS-1:0]            req_customer_id,
   // Result channel
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_kind,
   output logic [ID_BITS-1:0]                 rsp_who,
   output logic [1:0]                         rsp_granted_direction,
   output logic [dba_pkg::OCC_W-1:0]          rsp_occupancy,
   output logic                               rsp_last,
   // Configuration channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [dba_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dba_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int CAP_W  = $clog2(MAX_CAPACITY + 1);
   localparam int EC_W   = (CAP_W > dba_pkg::CFG_W) ? CAP_W : dba_pkg::CFG_W;
   localparam int OCC_W  = dba_pkg::OCC_W;
   localparam int BAT_W  = dba_pkg::BATCH_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_EMIT,
      ST_FETCH,
      ST_POP
   } state_type;

   // Control and state registers
   state_type                 state_ff, state_in;
   logic [dba_pkg::CFG_W-1:0] capacity_ff, capacity_in;
   logic [dba_pkg::CFG_W-1:0] batch_limit_ff, batch_limit_in;
   dba_pkg::dir_type          active_ff, active_in;
   logic [OCC_W-1:0]          users_ff, users_in;
   logic [BAT_W-1:0]          batch_ff, batch_in;
   logic [CNT_W-1:0]          count_ff [2];
   logic [CNT_W-1:0]          count_in [2];
   logic [PTR_W-1:0]          head_ff [2];
   logic [PTR_W-1:0]          head_in [2];
   logic [PTR_W-1:0]          tail_ff [2];
   logic [PTR_W-1:0]          tail_in [2];
   logic                      drain_ff, drain_in;

   // Latched event
   logic                      mode_ff, mode_in;
   logic                      side_ff, side_in;
   logic [ID_BITS-1:0]        id_ff, id_in;

   // Pending result
   dba_pkg::kind_type         kind_ff, kind_in;
   logic [ID_BITS-1:0]        who_ff, who_in;

   // Result registers
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_kind_ff, rsp_kind_in;
   logic [ID_BITS-1:0]        rsp_who_ff, rsp_who_in;
   logic [1:0]                rsp_dir_ff, rsp_dir_in;
   logic [OCC_W-1:0]          rsp_occ_ff, rsp_occ_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Queue memories
   logic [ID_BITS-1:0]        up_mem [QUEUE_DEPTH];
   logic [ID_BITS-1:0]        dn_mem [QUEUE_DEPTH];
   logic [ID_BITS-1:0]        up_rd_ff;
   logic [ID_BITS-1:0]        dn_rd_ff;
   logic                      push_en;

   // Shared admission check
   logic                      chk_side;
   dba_pkg::dir_type          chk_dir;
   logic [EC_W-1:0]           eff_cap;
   logic [BAT_W-1:0]          eff_limit;
   logic                      may_enter;

   logic                      act_side;
   logic                      chain;

   assign act_side = (active_ff == dba_pkg::DIR_DN);

   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = EC_W'(1);
      end else if (EC_W'(capacity_ff) > EC_W'(MAX_CAPACITY)) begin
         eff_cap = EC_W'(MAX_CAPACITY);
      end else begin
         eff_cap = EC_W'(capacity_ff);
      end
   end

   assign eff_limit = (batch_limit_ff == '0) ? BAT_W'(1) : BAT_W'(batch_limit_ff);

   // The check runs on the event's side while deciding, else on the active side.
   assign chk_side  = (state_ff == ST_DECIDE) ? side_ff : act_side;
   assign chk_dir   = dba_pkg::side_to_dir(chk_side);
   assign may_enter = (active_ff == dba_pkg::DIR_NONE) ||
                      ((active_ff == chk_dir) &&
                       (EC_W'(users_ff) < eff_cap) &&
                       !((count_ff[!chk_side] != '0) && (batch_ff >= eff_limit)));

   // A left beat or a drained admission is followed by another admission if the
   // active queue's head may enter now.
   assign chain = ((kind_ff == dba_pkg::KIND_LEFT) || drain_ff) &&
                  (active_ff != dba_pkg::DIR_NONE) &&
                  (count_ff[act_side] != '0) && may_enter;

   always_comb begin
      state_in       = state_ff;
      capacity_in    = capacity_ff;
      batch_limit_in = batch_limit_ff;
      active_in      = active_ff;
      users_in       = users_ff;
      batch_in       = batch_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      drain_in       = drain_ff;
      mode_in        = mode_ff;
      side_in        = side_ff;
      id_in          = id_ff;
      kind_in        = kind_ff;
      who_in         = who_ff;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_who_in     = rsp_who_ff;
      rsp_dir_in     = rsp_dir_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_last_in    = rsp_last_ff;
      push_en        = 1'b0;

      if (csr_valid) begin
         unique case (dba_pkg::csr_index_type'(csr_index))
            dba_pkg::CSR_CAPACITY:    capacity_in    = csr_wdata;
            dba_pkg::CSR_BATCH_LIMIT: batch_limit_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               side_in  = req_direction;
               id_in    = req_customer_id;
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            who_in   = id_ff;
            drain_in = 1'b0;
            state_in = ST_EMIT;
            if (mode_ff == dba_pkg::MODE_ARRIVE) begin
               if ((count_ff[side_ff] == '0) && may_enter) begin
                  if (active_ff == dba_pkg::DIR_NONE) begin
                     active_in = dba_pkg::side_to_dir(side_ff);
                     batch_in  = BAT_W'(1);
                  end else if (batch_ff != dba_pkg::BATCH_SAT) begin
                     batch_in = batch_ff + BAT_W'(1);
                  end
                  users_in = users_ff + OCC_W'(1);
                  kind_in  = dba_pkg::KIND_ADMITTED;
               end else if (count_ff[side_ff] == CNT_W'(QUEUE_DEPTH)) begin
                  kind_in = dba_pkg::KIND_REJECTED;
               end else begin
                  push_en           = 1'b1;
                  tail_in[side_ff]  = (tail_ff[side_ff] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                      '0 : tail_ff[side_ff] + PTR_W'(1);
                  count_in[side_ff] = count_ff[side_ff] + CNT_W'(1);
                  kind_in           = dba_pkg::KIND_QUEUED;
               end
            end else if (users_ff == '0) begin
               kind_in = dba_pkg::KIND_REJECTED;
            end else begin
               users_in = users_ff - OCC_W'(1);
               kind_in  = dba_pkg::KIND_LEFT;
               if (users_ff == OCC_W'(1)) begin
                  batch_in = '0;
                  // Prefer the opposite side, then the own side, then up, then down.
                  priority if ((active_ff != dba_pkg::DIR_NONE) &&
                               (count_ff[!act_side] != '0)) begin
                     active_in = dba_pkg::side_to_dir(!act_side);
                  end else if ((active_ff != dba_pkg::DIR_NONE) &&
                               (count_ff[act_side] != '0)) begin
                     active_in = active_ff;
                  end else if (count_ff[0] != '0) begin
                     active_in = dba_pkg::DIR_UP;
                  end else if (count_ff[1] != '0) begin
                     active_in = dba_pkg::DIR_DN;
                  end else begin
                     active_in = dba_pkg::DIR_NONE;
                  end
               end
            end
         end

         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = kind_ff;
            rsp_who_in   = who_ff;
            rsp_dir_in   = active_ff;
            rsp_occ_in   = users_ff;
            rsp_last_in  = !chain;
            state_in     = chain ? ST_FETCH : ST_IDLE;
         end

         ST_FETCH: begin
            // The queue head is read into the memory output register here.
            state_in = ST_POP;
         end

         ST_POP: begin
            who_in             = act_side ? dn_rd_ff : up_rd_ff;
            head_in[act_side]  = (head_ff[act_side] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : head_ff[act_side] + PTR_W'(1);
            count_in[act_side] = count_ff[act_side] - CNT_W'(1);
            users_in           = users_ff + OCC_W'(1);
            if (batch_ff != dba_pkg::BATCH_SAT) begin
               batch_in = batch_ff + BAT_W'(1);
            end
            kind_in  = dba_pkg::KIND_ADMITTED;
            drain_in = 1'b1;
            state_in = ST_EMIT;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         capacity_ff    <= dba_pkg::CFG_W'(1);
         batch_limit_ff <= dba_pkg::CFG_W'(1);
         active_ff      <= dba_pkg::DIR_NONE;
         users_ff       <= '0;
         batch_ff       <= '0;
         count_ff       <= '{default: '0};
         head_ff        <= '{default: '0};
         tail_ff        <= '{default: '0};
         drain_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         capacity_ff    <= capacity_in;
         batch_limit_ff <= batch_limit_in;
         active_ff      <= active_in;
         users_ff       <= users_in;
         batch_ff       <= batch_in;
         count_ff       <= count_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         drain_ff       <= drain_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      side_ff     <= side_in;
      id_ff       <= id_in;
      kind_ff     <= kind_in;
      who_ff      <= who_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_who_ff  <= rsp_who_in;
      rsp_dir_ff  <= rsp_dir_in;
      rsp_occ_ff  <= rsp_occ_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Queue memories: one write at the tail, a registered read of the head.
   always_ff @(posedge clock) begin
      if (push_en && !side_ff) begin
         up_mem[tail_ff[0]] <= id_ff;
      end
      up_rd_ff <= up_mem[head_ff[0]];
   end

   always_ff @(posedge clock) begin
      if (push_en && side_ff) begin
         dn_mem[tail_ff[1]] <= id_ff;
      end
      dn_rd_ff <= dn_mem[head_ff[1]];
   end

   assign busy                  = (state_ff != ST_IDLE);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = rsp_kind_ff;
   assign rsp_who               = rsp_who_ff;
   assign rsp_granted_direction = rsp_dir_ff;
   assign rsp_occupancy         = rsp_occ_ff;
   assign rsp_last              = rsp_last_ff;

   // The final beat of an event coincides with the block being free again.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("final result beat while still busy");

   // Every result beat comes out of an event in progress.
   a_beat_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without an event in progress");

   // An admission always leaves a direction granted.
   a_admit_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == dba_pkg::KIND_ADMITTED) |->
      (rsp_granted_direction != dba_pkg::DIR_NONE))
      else $error("admission reported with no active direction");

   // With no direction granted the resource must be empty.
   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      (active_ff == dba_pkg::DIR_NONE) |-> (users_ff == '0))
      else $error("users on the resource with no active direction");

   // Queue counts stay within the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff[0] <= CNT_W'(QUEUE_DEPTH)) && (count_ff[1] <= CNT_W'(QUEUE_DEPTH)))
      else $error("wait queue count beyond its depth");

endmodule

`default_nettype wire
